@@ hw/rtl/prx_pkg.sv @@
// prx_pkg: types, constants and the saturation helper shared by the point rotation block.
// No dependencies; compile before every other file in hw/rtl.
package prx_pkg;

  // Coordinate format: signed Q16.8
  localparam int COORD_WIDTH = 24;
  // Trig format: signed Q2.14
  localparam int TRIG_WIDTH  = 16;
  localparam int FRAC_BITS   = 14;
  // Sine widened by one bit so that it can be negated without overflow
  localparam int SIN_WIDTH   = TRIG_WIDTH + 1;
  localparam int PROD_WIDTH  = COORD_WIDTH + SIN_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;
  localparam int QUOT_WIDTH  = SUM_WIDTH - FRAC_BITS;

  // Configuration port
  localparam int PADDR_WIDTH = 5;
  localparam int PDATA_WIDTH = 32;
  localparam int IDX_WIDTH   = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
  typedef logic signed [SIN_WIDTH-1:0]   sin_t;

  // Register indexes
  typedef enum logic [IDX_WIDTH-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    trig_t cos_x;
    trig_t sin_x;
    trig_t cos_y;
    trig_t sin_y;
    trig_t cos_z;
    trig_t sin_z;
  } rot_cfg_t;

  typedef struct packed {
    coord_t x_in;
    coord_t y_in;
    coord_t z_in;
    logic   last_in;
  } pt_in_t;

  typedef struct packed {
    coord_t x_out;
    coord_t y_out;
    coord_t z_out;
    logic   clipped;
    logic   last_out;
  } pt_out_t;

  // Data that rides alongside a rotation unchanged (clip is ORed)
  typedef struct packed {
    coord_t other;
    logic   clip;
    logic   last;
  } side_t;

  typedef struct packed {
    coord_t val;
    logic   clip;
  } sat_res_t;

  // Saturate a floored quotient to the coordinate range
  function automatic sat_res_t sat_coord(input logic signed [QUOT_WIDTH-1:0] q);
    logic [QUOT_WIDTH-COORD_WIDTH:0] top;
    sat_res_t res;
    top = q[QUOT_WIDTH-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      res.val  = q[COORD_WIDTH-1:0];
      res.clip = 1'b0;
    end else if (q[QUOT_WIDTH-1]) begin
      res.val  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      res.clip = 1'b1;
    end else begin
      res.val  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      res.clip = 1'b1;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/point_rotate_xyz.sv @@
// point_rotate_xyz: rotates a Q16.8 point about X, then Y, then Z with saturation.
// Depends on prx_pkg, prx_rot and prx_apb_regs.
//
//   channel   handshake                      payload
//   input     start (taken while busy low)   in_item  (pt_in_t)
//   result    out_valid, one cycle, no stall out_item (pt_out_t)
//   config    psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// An item is taken every cycle; busy is never raised. Each item passes from
// start to out_valid through three rotations of two stages each (a
// multiply stage and an add/shift/saturate stage). Synchronous reset clears
// the stage valid bits and loads identity angles. The receiver cannot stall,
// so results leave in order, straight from the last stage register.
module point_rotate_xyz (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  prx_pkg::pt_in_t                in_item,
  output logic                           out_valid,
  output prx_pkg::pt_out_t               out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prx_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [prx_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [prx_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                           pready
);
  import prx_pkg::*;

  rot_cfg_t cfg;
  side_t    side_x_in, side_x_out, side_y_in, side_y_out, side_z_in, side_z_out;
  coord_t   y1, z1, x2, z2, x3, y3;
  logic     v_x, v_y, v_z;
  sin_t     sin_x_w, sin_y_neg, sin_z_w;

  assign busy = 1'b0;

  prx_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Widen the sines; the Y rotation takes the negated sine to flip its signs
  assign sin_x_w   = SIN_WIDTH'(cfg.sin_x);
  assign sin_y_neg = -SIN_WIDTH'(cfg.sin_y);
  assign sin_z_w   = SIN_WIDTH'(cfg.sin_z);

  // About X: y' = y*c - z*s, z' = z*c + y*s; x rides along
  always_comb begin
    side_x_in.other = in_item.x_in;
    side_x_in.clip  = 1'b0;
    side_x_in.last  = in_item.last_in;
  end

  prx_rot u_rot_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start),
    .a_i     (in_item.y_in),
    .b_i     (in_item.z_in),
    .cos_i   (cfg.cos_x),
    .sin_i   (sin_x_w),
    .side_i  (side_x_in),
    .valid_o (v_x),
    .a_o     (y1),
    .b_o     (z1),
    .side_o  (side_x_out)
  );

  // About Y: x' = x*c + z*s, z' = z*c - x*s; y1 rides along
  always_comb begin
    side_y_in       = side_x_out;
    side_y_in.other = y1;
  end

  prx_rot u_rot_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v_x),
    .a_i     (side_x_out.other),
    .b_i     (z1),
    .cos_i   (cfg.cos_y),
    .sin_i   (sin_y_neg),
    .side_i  (side_y_in),
    .valid_o (v_y),
    .a_o     (x2),
    .b_o     (z2),
    .side_o  (side_y_out)
  );

  // About Z: x' = x*c - y*s, y' = y*c + x*s; z2 rides along
  always_comb begin
    side_z_in       = side_y_out;
    side_z_in.other = z2;
  end

  prx_rot u_rot_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v_y),
    .a_i     (x2),
    .b_i     (side_y_out.other),
    .cos_i   (cfg.cos_z),
    .sin_i   (sin_z_w),
    .side_i  (side_z_in),
    .valid_o (v_z),
    .a_o     (x3),
    .b_o     (y3),
    .side_o  (side_z_out)
  );

  // Present the item straight from the last stage register
  always_comb begin
    out_item.x_out    = x3;
    out_item.y_out    = y3;
    out_item.z_out    = side_z_out.other;
    out_item.clipped  = side_z_out.clip;
    out_item.last_out = side_z_out.last;
  end

  assign out_valid = v_z;

endmodule

@@ hw/rtl/prx_rot.sv @@
// prx_rot: one plane rotation, a' = a*c - b*s, b' = b*c + a*s, in two register stages.
// Depends on prx_pkg (coordinate types, widths, sat_coord).
module prx_rot (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  prx_pkg::coord_t a_i,
  input  prx_pkg::coord_t b_i,
  input  prx_pkg::trig_t  cos_i,
  input  prx_pkg::sin_t   sin_i,
  input  prx_pkg::side_t  side_i,
  output logic           valid_o,
  output prx_pkg::coord_t a_o,
  output prx_pkg::coord_t b_o,
  output prx_pkg::side_t  side_o
);
  import prx_pkg::*;

  logic signed [PROD_WIDTH-1:0] ac_r, bs_r, bc_r, as_r;
  logic signed [PROD_WIDTH-1:0] ac_nxt, bs_nxt, bc_nxt, as_nxt;
  logic                         v1_r;
  side_t                        side1_r;

  logic signed [SUM_WIDTH-1:0]  sum_a, sum_b;
  sat_res_t                     sat_a, sat_b;
  logic                         v2_r;
  coord_t                       a2_r, b2_r;
  side_t                        side2_r, side2_nxt;

  // Multiply stage: four products, exact
  always_comb begin
    ac_nxt = PROD_WIDTH'(a_i) * PROD_WIDTH'(cos_i);
    bs_nxt = PROD_WIDTH'(b_i) * PROD_WIDTH'(sin_i);
    bc_nxt = PROD_WIDTH'(b_i) * PROD_WIDTH'(cos_i);
    as_nxt = PROD_WIDTH'(a_i) * PROD_WIDTH'(sin_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
    end
    ac_r    <= ac_nxt;
    bs_r    <= bs_nxt;
    bc_r    <= bc_nxt;
    as_r    <= as_nxt;
    side1_r <= side_i;
  end

  // Sum stage: add, floor-shift by the fraction bits, saturate
  always_comb begin
    sum_a = SUM_WIDTH'(ac_r) - SUM_WIDTH'(bs_r);
    sum_b = SUM_WIDTH'(bc_r) + SUM_WIDTH'(as_r);
    sat_a = sat_coord(sum_a[SUM_WIDTH-1:FRAC_BITS]);
    sat_b = sat_coord(sum_b[SUM_WIDTH-1:FRAC_BITS]);
    side2_nxt      = side1_r;
    side2_nxt.clip = side1_r.clip | sat_a.clip | sat_b.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    a2_r    <= sat_a.val;
    b2_r    <= sat_b.val;
    side2_r <= side2_nxt;
  end

  assign valid_o = v2_r;
  assign a_o     = a2_r;
  assign b_o     = b2_r;
  assign side_o  = side2_r;

endmodule

@@ hw/rtl/prx_apb_regs.sv @@
// prx_apb_regs: APB-style register file for the six Q2.14 cosine/sine registers.
// Depends on prx_pkg (rot_cfg_t, register indexes, port widths).
module prx_apb_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prx_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [prx_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [prx_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                           pready,
  output prx_pkg::rot_cfg_t              cfg_o
);
  import prx_pkg::*;

  rot_cfg_t             cfg_r;
  logic [IDX_WIDTH-1:0] idx;
  logic                 wr_en;
  trig_t                rd_val;
  trig_t                wr_val;

  assign idx    = paddr[PADDR_WIDTH-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign wr_val = pwdata[TRIG_WIDTH-1:0];
  assign pready = 1'b1;

  // Write on the access cycle; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_x <= trig_t'(1 << FRAC_BITS);
      cfg_r.sin_x <= '0;
      cfg_r.cos_y <= trig_t'(1 << FRAC_BITS);
      cfg_r.sin_y <= '0;
      cfg_r.cos_z <= trig_t'(1 << FRAC_BITS);
      cfg_r.sin_z <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_COS_X: cfg_r.cos_x <= wr_val;
        REG_SIN_X: cfg_r.sin_x <= wr_val;
        REG_COS_Y: cfg_r.cos_y <= wr_val;
        REG_SIN_Y: cfg_r.sin_y <= wr_val;
        REG_COS_Z: cfg_r.cos_z <= wr_val;
        REG_SIN_Z: cfg_r.sin_z <= wr_val;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_COS_X: rd_val = cfg_r.cos_x;
      REG_SIN_X: rd_val = cfg_r.sin_x;
      REG_COS_Y: rd_val = cfg_r.cos_y;
      REG_SIN_Y: rd_val = cfg_r.sin_y;
      REG_COS_Z: rd_val = cfg_r.cos_z;
      REG_SIN_Z: rd_val = cfg_r.sin_z;
      default:   rd_val = '0;
    endcase
  end

  assign prdata = {{(PDATA_WIDTH-TRIG_WIDTH){1'b0}}, rd_val};
  assign cfg_o  = cfg_r;

endmodule
